// ----- src/nfpf_pkg.sv -----
// Shared constants, types and command/status structs for the fast-packet framer.
package nfpf_pkg;

    localparam int MAX_PAYLOAD = 223;
    localparam int CNT_W       = $clog2(MAX_PAYLOAD + 1);
    localparam int ADDR_W      = $clog2(MAX_PAYLOAD);
    localparam int FRAME_W     = 5;
    localparam int SLOT_W      = 3;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 17;
    localparam int ID_W        = 29;
    localparam int DATA_W      = 64;

    localparam logic [SLOT_W-1:0] SLOT_FIRST = '0;
    localparam logic [SLOT_W-1:0] SLOT_LEN   = SLOT_W'(1);
    localparam logic [SLOT_W-1:0] SLOT_LAST  = '1;
    localparam logic [7:0]        FILL_BYTE  = 8'hFF;
    localparam logic [7:0]        PF_PDU2    = 8'd240;
    localparam logic [CNT_W:0]    BYTES_PER_FRAME = (CNT_W + 1)'(7);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PRIORITY = 2'd0,
        CFG_PGN      = 2'd1,
        CFG_SOURCE   = 2'd2,
        CFG_DEST     = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_PUSH,
        ST_ERR
    } state_t;

    typedef struct packed {
        logic store;
        logic close;
        logic rd_step;
        logic push_frame;
        logic next_frame;
        logic push_error;
    } cmd_t;

    typedef struct packed {
        logic bad;
        logic slot_done;
        logic last_frame;
        logic out_free;
    } sts_t;

endpackage

// ----- src/nfpf_payload_if.sv -----
// Payload byte channel: one message byte per word.
interface nfpf_payload_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;
    logic [2:0] seq_id;

    modport source (output valid, output data_byte, output last_byte, output seq_id,
                    input ready);
    modport sink   (input valid, input data_byte, input last_byte, input seq_id,
                    output ready);
endinterface

// ----- src/nfpf_frame_if.sv -----
// Frame channel: one CAN frame or one error marker per word.
interface nfpf_frame_if;
    logic        valid;
    logic        ready;
    logic [28:0] frame_id;
    logic [63:0] frame_data;
    logic        last_frame;
    logic        error;

    modport source (output valid, output frame_id, output frame_data, output last_frame,
                    output error, input ready);
    modport sink   (input valid, input frame_id, input frame_data, input last_frame,
                    input error, output ready);
endinterface

// ----- src/nmea2000_fast_packet_framer_unit.sv -----
// Top level: NMEA 2000 fast-packet framer.
// Bytes are taken one per cycle while loading; once the closing byte is accepted, each
// frame is assembled (8 assembly steps per frame, at most 7 of them buffer reads) and
// then pushed once the output register is free. A message of n bytes gives 1 + n/7
// frames; an oversized one gives one error word instead. Input stalls while frames
// are assembled. Reset (rst_n, async low) restores register defaults and clears the
// byte, frame and slot counters; the payload buffer is not cleared.
module nmea2000_fast_packet_framer_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [nfpf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [nfpf_pkg::CFG_DATA_W-1:0] cfg_data,
    nfpf_payload_if.sink                    payload,
    nfpf_frame_if.source                    frame
);

    nfpf_pkg::cmd_t cmd;
    nfpf_pkg::sts_t sts;

    nfpf_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (payload.valid),
        .in_last  (payload.last_byte),
        .in_ready (payload.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    nfpf_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .cmd         (cmd),
        .sts         (sts),
        .data_byte   (payload.data_byte),
        .seq_id      (payload.seq_id),
        .frame_ready (frame.ready),
        .frame_valid (frame.valid),
        .frame_id    (frame.frame_id),
        .frame_data  (frame.frame_data),
        .last_frame  (frame.last_frame),
        .error       (frame.error)
    );

endmodule

// ----- src/nfpf_datapath.sv -----
// Datapath: config registers, payload buffer, frame assembly and output register.
module nfpf_datapath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [nfpf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [nfpf_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  nfpf_pkg::cmd_t                     cmd,
    output nfpf_pkg::sts_t                     sts,
    input  logic [7:0]                         data_byte,
    input  logic [2:0]                         seq_id,
    input  logic                               frame_ready,
    output logic                               frame_valid,
    output logic [nfpf_pkg::ID_W-1:0]          frame_id,
    output logic [nfpf_pkg::DATA_W-1:0]        frame_data,
    output logic                               last_frame,
    output logic                               error
);

    localparam int CW = nfpf_pkg::CNT_W;
    localparam int AW = nfpf_pkg::ADDR_W;

    logic [2:0]  priority_reg;
    logic [16:0] pgn_reg;
    logic [7:0]  source_reg;
    logic [7:0]  dest_reg;

    logic [7:0] mem [nfpf_pkg::MAX_PAYLOAD];
    logic [7:0] mem_q_reg;
    logic       valid_q_reg;

    logic [CW-1:0] byte_count_reg, byte_count_next;
    logic          overflow_reg, overflow_next;
    logic [CW-1:0] len_reg, len_next;
    logic [2:0]    seq_reg, seq_next;
    logic [nfpf_pkg::FRAME_W-1:0] frame_reg, frame_next;
    logic [nfpf_pkg::SLOT_W-1:0]  slot_reg, slot_next;
    logic [CW-1:0] off_reg, off_next;
    logic [CW-1:0] base_reg, base_next;
    logic [nfpf_pkg::DATA_W-1:0] asm_reg, asm_next;

    logic          out_valid_reg;
    logic [nfpf_pkg::ID_W-1:0]   out_id_reg;
    logic [nfpf_pkg::DATA_W-1:0] out_data_reg;
    logic          out_last_reg;
    logic          out_error_reg;

    logic          full;
    logic          next_is_data;
    logic          issue_rd;
    logic [7:0]    slot_byte;
    logic [CW:0]   frame_end;
    logic [16:0]   pgn_field;
    logic [nfpf_pkg::ID_W-1:0] id_value;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            priority_reg <= 3'd6;
            pgn_reg      <= '0;
            source_reg   <= '0;
            dest_reg     <= 8'hFF;
        end
        else if (cfg_we)
        begin
            case (nfpf_pkg::cfg_index_t'(cfg_index))
                nfpf_pkg::CFG_PRIORITY: priority_reg <= cfg_data[2:0];
                nfpf_pkg::CFG_PGN:      pgn_reg      <= cfg_data[16:0];
                nfpf_pkg::CFG_SOURCE:   source_reg   <= cfg_data[7:0];
                nfpf_pkg::CFG_DEST:     dest_reg     <= cfg_data[7:0];
                default:                priority_reg <= priority_reg;
            endcase
        end
    end

    // PDU1 groups carry the destination in the PS byte
    assign pgn_field = (pgn_reg[15:8] < nfpf_pkg::PF_PDU2) ? {pgn_reg[16:8], dest_reg}
                                                            : pgn_reg;
    assign id_value  = {priority_reg, 1'b0, pgn_field, source_reg};

    assign full         = (byte_count_reg == CW'(nfpf_pkg::MAX_PAYLOAD));
    assign next_is_data = !((slot_reg == nfpf_pkg::SLOT_FIRST) && (frame_reg == '0));
    assign issue_rd     = cmd.rd_step && (slot_reg != nfpf_pkg::SLOT_LAST) && next_is_data
                          && (off_reg < len_reg);
    assign frame_end    = {1'b0, base_reg} + nfpf_pkg::BYTES_PER_FRAME;

    always_comb
    begin
        if (slot_reg == nfpf_pkg::SLOT_FIRST)
            slot_byte = {seq_reg, frame_reg};
        else if ((slot_reg == nfpf_pkg::SLOT_LEN) && (frame_reg == '0))
            slot_byte = 8'(len_reg);
        else if (valid_q_reg)
            slot_byte = mem_q_reg;
        else
            slot_byte = nfpf_pkg::FILL_BYTE;
    end

    always_comb
    begin
        byte_count_next = byte_count_reg;
        overflow_next   = overflow_reg;
        len_next        = len_reg;
        seq_next        = seq_reg;
        frame_next      = frame_reg;
        slot_next       = slot_reg;
        off_next        = off_reg;
        base_next       = base_reg;
        asm_next        = asm_reg;

        if (cmd.store)
        begin
            if (full)
                overflow_next = 1'b1;
            else
                byte_count_next = byte_count_reg + CW'(1);
        end
        if (cmd.close)
        begin
            len_next        = full ? byte_count_reg : byte_count_reg + CW'(1);
            seq_next        = seq_id;
            byte_count_next = '0;
            overflow_next   = 1'b0;
            frame_next      = '0;
            slot_next       = '0;
            off_next        = '0;
            base_next       = '0;
        end
        if (cmd.rd_step)
        begin
            asm_next  = {slot_byte, asm_reg[nfpf_pkg::DATA_W-1:8]};
            slot_next = slot_reg + nfpf_pkg::SLOT_W'(1);
            if (issue_rd)
                off_next = off_reg + CW'(1);
        end
        if (cmd.next_frame)
        begin
            frame_next = frame_reg + nfpf_pkg::FRAME_W'(1);
            slot_next  = '0;
            base_next  = CW'(frame_end);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
            overflow_reg   <= 1'b0;
            frame_reg      <= '0;
            slot_reg       <= '0;
            valid_q_reg    <= 1'b0;
        end
        else
        begin
            byte_count_reg <= byte_count_next;
            overflow_reg   <= overflow_next;
            frame_reg      <= frame_next;
            slot_reg       <= slot_next;
            if (cmd.rd_step)
                valid_q_reg <= issue_rd;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg  <= len_next;
        seq_reg  <= seq_next;
        off_reg  <= off_next;
        base_reg <= base_next;
        asm_reg  <= asm_next;
    end

    // Payload buffer, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.store && !full)
            mem[byte_count_reg[AW-1:0]] <= data_byte;
        if (issue_rd)
            mem_q_reg <= mem[off_reg[AW-1:0]];
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.push_frame || cmd.push_error)
            out_valid_reg <= 1'b1;
        else if (frame_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push_frame)
        begin
            out_id_reg    <= id_value;
            out_data_reg  <= asm_reg;
            out_last_reg  <= sts.last_frame;
            out_error_reg <= 1'b0;
        end
        else if (cmd.push_error)
        begin
            out_id_reg    <= '0;
            out_data_reg  <= '0;
            out_last_reg  <= 1'b0;
            out_error_reg <= 1'b1;
        end
    end

    assign sts.bad        = overflow_reg || full;
    assign sts.slot_done  = (slot_reg == nfpf_pkg::SLOT_LAST);
    assign sts.last_frame = ({1'b0, len_reg} < frame_end);
    assign sts.out_free   = !out_valid_reg || frame_ready;

    assign frame_valid = out_valid_reg;
    assign frame_id    = out_id_reg;
    assign frame_data  = out_data_reg;
    assign last_frame  = out_last_reg;
    assign error       = out_error_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        byte_count_reg <= CW'(nfpf_pkg::MAX_PAYLOAD))
        else $error("byte count beyond buffer depth");

    a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.push_frame || cmd.push_error) |-> sts.out_free)
        else $error("output word overwritten before it was taken");

    a_close_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.close |=> (byte_count_reg == '0) && !overflow_reg)
        else $error("message close left stale count");

endmodule

// ----- src/nfpf_controller.sv -----
// Controller: sequences byte loading, frame assembly and result push.
module nfpf_controller (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic           in_last,
    output logic           in_ready,
    input  nfpf_pkg::sts_t sts,
    output nfpf_pkg::cmd_t cmd
);

    nfpf_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= nfpf_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            nfpf_pkg::ST_IDLE:
            begin
                if (in_valid && in_last)
                    state_next = sts.bad ? nfpf_pkg::ST_ERR : nfpf_pkg::ST_READ;
            end
            nfpf_pkg::ST_READ:
            begin
                if (sts.slot_done)
                    state_next = nfpf_pkg::ST_PUSH;
            end
            nfpf_pkg::ST_PUSH:
            begin
                if (sts.out_free)
                    state_next = sts.last_frame ? nfpf_pkg::ST_IDLE : nfpf_pkg::ST_READ;
            end
            nfpf_pkg::ST_ERR:
            begin
                if (sts.out_free)
                    state_next = nfpf_pkg::ST_IDLE;
            end
            default: state_next = nfpf_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        case (state_reg)
            nfpf_pkg::ST_IDLE:
            begin
                in_ready  = 1'b1;
                cmd.store = in_valid;
                cmd.close = in_valid && in_last;
            end
            nfpf_pkg::ST_READ:
            begin
                cmd.rd_step = 1'b1;
            end
            nfpf_pkg::ST_PUSH:
            begin
                // hold the assembled frame until the output register frees up
                cmd.push_frame = sts.out_free;
                cmd.next_frame = sts.out_free && !sts.last_frame;
            end
            nfpf_pkg::ST_ERR:
            begin
                cmd.push_error = sts.out_free;
            end
            default: cmd = '0;
        endcase
    end

    a_read_to_push: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == nfpf_pkg::ST_READ && sts.slot_done) |=> state_reg == nfpf_pkg::ST_PUSH)
        else $error("frame assembly did not hand over to push");

    a_bad_to_err: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.close && sts.bad) |=> state_reg == nfpf_pkg::ST_ERR)
        else $error("oversized message not routed to error");

    a_one_action: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.store, cmd.rd_step, cmd.push_frame, cmd.push_error}))
        else $error("conflicting datapath commands");

endmodule
